// ----- hdl/gwpp_pkg.sv -----
// Shared constants, types and helper functions of the gradient-weighted pixel predictor.
`default_nettype none

package gwpp_pkg;

  // Sample and line geometry
  localparam int SAMPLE_BITS   = 16;
  localparam int MAX_WIDTH     = 1024;
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS    = 11;
  localparam int HEIGHT_BITS   = 16;
  localparam int IO_BITS       = 17;
  localparam int EXT_BITS      = IO_BITS + 1;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // Weighted prediction datapath
  localparam int DIFF_BITS     = SAMPLE_BITS + 1;
  localparam int PROD_BITS     = 2 * SAMPLE_BITS + 1;
  localparam int NUM_BITS      = PROD_BITS + 1;
  localparam int DEN_BITS      = SAMPLE_BITS + 1;
  localparam int QUO_BITS      = SAMPLE_BITS + 1;
  localparam int CNT_BITS      = $clog2(QUO_BITS + 1);

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DECODE_MODE  = 2'd0,
    CFG_BLOCK_WIDTH  = 2'd1,
    CFG_BLOCK_HEIGHT = 2'd2
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_SUM,
    ST_START,
    ST_DIV,
    ST_FIN
  } pred_state_t;

  // Divider request and response
  typedef struct packed {
    logic                       start;
    logic signed [NUM_BITS-1:0] dividend;
    logic [DEN_BITS-1:0]        divisor;
  } div_cmd_t;

  typedef struct packed {
    logic                       done;
    logic signed [QUO_BITS-1:0] quotient;
  } div_rsp_t;

  // Saturate a widened value to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(
    input logic signed [EXT_BITS-1:0] v
  );
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > EXT_BITS'(SMP_MAX)) begin
      r = SMP_MAX;
    end else if (v < EXT_BITS'(SMP_MIN)) begin
      r = SMP_MIN;
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/gwpp_ifs.sv -----
// Valid/ready channel interfaces for input, result and configuration beats.
`default_nettype none

interface gwpp_in_if import gwpp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [IO_BITS-1:0] data_in;

  modport source (output valid, output data_in, input ready);
  modport sink   (input valid, input data_in, output ready);
endinterface

interface gwpp_out_if import gwpp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [IO_BITS-1:0] data_out;
  logic                      end_of_block;

  modport source (output valid, output data_out, output end_of_block, input ready);
  modport sink   (input valid, input data_out, input end_of_block, output ready);
endinterface

interface gwpp_cfg_if import gwpp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/gwpp_div.sv -----
// Bit-serial signed divider: one quotient bit per cycle, truncating toward zero.
`default_nettype none

module gwpp_div
  import gwpp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_cmd_t cmd,
  output div_rsp_t rsp
);

  logic [DEN_BITS-1:0] rem_r;
  logic [DEN_BITS-1:0] rem_nxt;
  logic [QUO_BITS-1:0] quo_r;
  logic [QUO_BITS-1:0] quo_nxt;
  logic [DEN_BITS-1:0] den_r;
  logic                neg_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [NUM_BITS-1:0] mag;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;

  // Magnitude of the dividend; the quotient fits QUO_BITS, so the top bits start as remainder
  always_comb begin
    mag = cmd.dividend[NUM_BITS-1] ? NUM_BITS'(-cmd.dividend) : cmd.dividend;
  end

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, quo_r[QUO_BITS-1]};
    diff  = trial - {1'b0, den_r};
    if (!diff[DEN_BITS]) begin
      rem_nxt = diff[DEN_BITS-1:0];
      quo_nxt = {quo_r[QUO_BITS-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DEN_BITS-1:0];
      quo_nxt = {quo_r[QUO_BITS-2:0], 1'b0};
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_BITS'(1));
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(QUO_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r <= DEN_BITS'(mag[NUM_BITS-2:QUO_BITS]);
      quo_r <= mag[QUO_BITS-1:0];
      den_r <= cmd.divisor;
      neg_r <= cmd.dividend[NUM_BITS-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

`default_nettype wire

// ----- hdl/gradient_weighted_pixel_predictor.sv -----
// Top level of the gradient-weighted pixel predictor: sequencer, line store and result register.
//
//   Channel  | Dir | Payload                                | Beat when
//   ---------+-----+----------------------------------------+--------------------------
//   cfg_ch   | in  | index[1:0], data[15:0]                 | cfg_ch.valid & ready
//   in_ch    | in  | data_in[16:0] signed                   | in_ch.valid & ready
//   out_ch   | out | data_out[16:0] signed, end_of_block    | out_ch.valid & ready
//
// Corner, top-row, left-column and flat positions go from ST_READ through ST_MUL to ST_FIN;
// other positions pass ST_SUM, ST_START and the 17-step bit-serial divider in ST_DIV first.
// A new input beat is taken in the cycle after the result is registered.
// rst_n is synchronous; the line store is not cleared, every entry is written before its value is used.
// A stall on out_ch holds the next item at its final step, and input waits behind it.
// cfg_ch is always ready; a write to a defined register restarts the block at its first position.
`default_nettype none

module gradient_weighted_pixel_predictor
  import gwpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  gwpp_cfg_if.sink   cfg_ch,
  gwpp_in_if.sink    in_ch,
  gwpp_out_if.source out_ch
);

  pred_state_t state_r;
  pred_state_t state_nxt;

  // Configuration
  logic                   decode_r;
  logic [WIDTH_BITS-1:0]  width_r;
  logic [HEIGHT_BITS-1:0] height_r;
  logic [WIDTH_BITS-1:0]  width_wr;
  logic [HEIGHT_BITS-1:0] height_wr;
  logic                   cfg_wr;
  logic                   cfg_restart;

  // Position and neighbors
  logic [COL_BITS-1:0]          col_r;
  logic [HEIGHT_BITS-1:0]       row_r;
  logic signed [SAMPLE_BITS-1:0] w_r;
  logic signed [SAMPLE_BITS-1:0] nw_r;

  // Line store
  logic signed [SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] mem_q_r;

  // Item datapath
  logic signed [IO_BITS-1:0]     din_r;
  logic signed [SAMPLE_BITS-1:0] n_r;
  logic signed [SAMPLE_BITS-1:0] n_sel;
  logic signed [DIFF_BITS-1:0]   dn;
  logic signed [DIFF_BITS-1:0]   dw;
  logic [SAMPLE_BITS-1:0]        dh_r;
  logic [SAMPLE_BITS-1:0]        dv_r;
  logic signed [PROD_BITS-1:0]   prod_r;
  logic signed [PROD_BITS-1:0]   ndh;
  logic signed [NUM_BITS-1:0]    num_r;
  logic [DEN_BITS-1:0]           den_r;

  // Control
  logic     in_ready;
  logic     fin_go;
  logic     div_start;
  logic     first_row;
  logic     first_col;
  logic     flat;
  logic     special;
  logic     last_col;
  logic     last_row;
  div_cmd_t div_cmd;
  div_rsp_t div_rsp;

  // Result
  logic signed [IO_BITS-1:0]     pred;
  logic signed [SAMPLE_BITS-1:0] cur;
  logic signed [IO_BITS-1:0]     res;
  logic                          out_valid_r;
  logic signed [IO_BITS-1:0]     out_data_r;
  logic                          out_eob_r;

  // Position flags
  assign first_row = (row_r == '0);
  assign first_col = (col_r == '0);
  assign flat      = (dh_r == '0) && (dv_r == '0);
  assign special   = first_row || first_col || flat;
  assign last_col  = (WIDTH_BITS'(col_r) + WIDTH_BITS'(1)) >= width_r;
  assign last_row  = ((HEIGHT_BITS+1)'(row_r) + (HEIGHT_BITS+1)'(1)) >= (HEIGHT_BITS+1)'(height_r);

  // Configuration decode: clamp the block size to its working range
  assign cfg_wr = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    width_wr = cfg_ch.data[WIDTH_BITS-1:0];
    if (width_wr == '0) begin
      width_wr = WIDTH_BITS'(1);
    end else if (width_wr > WIDTH_BITS'(MAX_WIDTH)) begin
      width_wr = WIDTH_BITS'(MAX_WIDTH);
    end
    height_wr = cfg_ch.data[HEIGHT_BITS-1:0];
    if (height_wr == '0) begin
      height_wr = HEIGHT_BITS'(1);
    end
  end

  always_comb begin
    cfg_restart = 1'b0;
    if (cfg_wr) begin
      case (cfg_reg_t'(cfg_ch.index))
        CFG_DECODE_MODE:  cfg_restart = 1'b1;
        CFG_BLOCK_WIDTH:  cfg_restart = 1'b1;
        CFG_BLOCK_HEIGHT: cfg_restart = 1'b1;
        default:          cfg_restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_r <= 1'b0;
      width_r  <= WIDTH_BITS'(1);
      height_r <= HEIGHT_BITS'(1);
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_ch.index))
        CFG_DECODE_MODE:  decode_r <= cfg_ch.data[0];
        CFG_BLOCK_WIDTH:  width_r  <= width_wr;
        CFG_BLOCK_HEIGHT: height_r <= height_wr;
        default:          decode_r <= decode_r;
      endcase
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state and strobes
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    fin_go    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = special ? ST_FIN : ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ST_START;
      end
      ST_START: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          fin_go    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;
  assign div_cmd      = '{start: div_start, dividend: num_r, divisor: den_r};

  gwpp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .rsp   (div_rsp)
  );

  // Line store: read the column above on the input beat, write the new sample when done
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      mem_q_r <= line_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      line_mem[col_r] <= cur;
    end
  end

  // Gradients against the upper-left neighbor
  assign n_sel = first_row ? '0 : mem_q_r;
  assign dn    = DIFF_BITS'(n_sel) - DIFF_BITS'(nw_r);
  assign dw    = DIFF_BITS'(w_r) - DIFF_BITS'(nw_r);
  assign ndh   = PROD_BITS'(n_r) * PROD_BITS'($signed({1'b0, dh_r}));

  // Item datapath registers
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      din_r <= in_ch.data_in;
    end
    if (state_r == ST_READ) begin
      n_r  <= n_sel;
      dh_r <= dn[DIFF_BITS-1] ? SAMPLE_BITS'(-dn) : SAMPLE_BITS'(dn);
      dv_r <= dw[DIFF_BITS-1] ? SAMPLE_BITS'(-dw) : SAMPLE_BITS'(dw);
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_BITS'(w_r) * PROD_BITS'($signed({1'b0, dv_r}));
    end
    if (state_r == ST_SUM) begin
      num_r <= NUM_BITS'(prod_r) + NUM_BITS'(ndh);
      den_r <= DEN_BITS'(dh_r) + DEN_BITS'(dv_r);
    end
  end

  // Prediction and result
  always_comb begin
    if (first_row && first_col) begin
      pred = '0;
    end else if (first_row) begin
      pred = IO_BITS'(w_r);
    end else if (first_col) begin
      pred = IO_BITS'(n_r);
    end else if (flat) begin
      pred = IO_BITS'(w_r);
    end else begin
      pred = div_rsp.quotient;
    end
    if (decode_r) begin
      cur = clamp_sample(EXT_BITS'(din_r) + EXT_BITS'(pred));
      res = IO_BITS'(cur);
    end else begin
      cur = clamp_sample(EXT_BITS'(din_r));
      res = IO_BITS'(EXT_BITS'(cur) - EXT_BITS'(pred));
    end
  end

  // Advance position and neighbors; a register write restarts the block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      w_r   <= '0;
      nw_r  <= '0;
    end else if (cfg_restart) begin
      col_r <= '0;
      row_r <= '0;
      w_r   <= '0;
      nw_r  <= '0;
    end else if (fin_go) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + HEIGHT_BITS'(1);
        w_r   <= '0;
        nw_r  <= '0;
      end else begin
        col_r <= col_r + COL_BITS'(1);
        w_r   <= cur;
        nw_r  <= n_r;
      end
    end
  end

  // Result register: load on completion, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_data_r <= res;
      out_eob_r  <= last_col && last_row;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.data_out     = out_data_r;
  assign out_ch.end_of_block = out_eob_r;

`ifndef SYNTHESIS
  a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_READ))
    else $error("input beat did not start the line store read");

  a_col_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    WIDTH_BITS'(col_r) < width_r)
    else $error("column count outside the block width");

  a_row_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    row_r < height_r)
    else $error("row count outside the block height");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  a_fin_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("completed item did not load the result register");
`endif

endmodule

`default_nettype wire
